FILE: rtl/core/vps_pkg.sv
package vps_pkg;

  // Default pool size.
  localparam int VOICE_SLOTS_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_LISTENER_X = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_LISTENER_Y = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_LISTENER_Z = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MASTER_GAIN = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MUTE_ALL = 3'd4;

  // Request opcodes.
  localparam logic [1:0] OP_PLAY = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_ENDED = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_STARTED = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;
  localparam logic [1:0] ST_NOT_BUSY = 2'd3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pos_t;

  typedef struct packed {
    logic [15:0] dmin;
    logic [15:0] dmax;
    logic [15:0] roll;
  } dist_t;

  // Inputs of one audibility evaluation.
  typedef struct packed {
    logic [15:0] gain;
    logic        spatial;
    pos_t        pos;
    dist_t       lims;
  } aud_req_t;

  // One stored voice record.
  typedef struct packed {
    logic [7:0]  prio;
    aud_req_t    aud;
    logic [15:0] order;
  } voice_t;

endpackage

FILE: rtl/core/vps_if.sv
interface vps_cmd_if;
  import vps_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [4:0]  target_slot;
  logic [7:0]  priority_req;
  logic [15:0] gain;
  logic        spatial;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [15:0] min_distance;
  logic [15:0] max_distance;
  logic [15:0] rolloff;

  modport source (
    output valid, opcode, target_slot, priority_req, gain, spatial,
           pos_x, pos_y, pos_z, min_distance, max_distance, rolloff,
    input  ready
  );
  modport sink (
    input  valid, opcode, target_slot, priority_req, gain, spatial,
           pos_x, pos_y, pos_z, min_distance, max_distance, rolloff,
    output ready
  );
endinterface

interface vps_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  voice_slot;
  logic [15:0] device_gain;
  logic        stole;
  logic [4:0]  victim_slot;
  logic [15:0] stolen_total;

  modport source (
    output valid, status, voice_slot, device_gain, stole, victim_slot, stolen_total,
    input  ready
  );
  modport sink (
    input  valid, status, voice_slot, device_gain, stole, victim_slot, stolen_total,
    output ready
  );
endinterface

FILE: rtl/core/vps_ram.sv
module vps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/vps_audibility.sv
module vps_audibility (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  vps_pkg::aud_req_t req,
  input  vps_pkg::pos_t     listener,
  output logic              done,
  output logic [15:0]       level
);
  import vps_pkg::*;

  typedef enum logic [3:0] {
    A_IDLE, A_DIFF, A_SQ, A_ROOT, A_CMP, A_ROLL, A_DEN, A_NUM, A_DIV, A_DONE
  } astate_t;

  astate_t     state;
  aud_req_t    cur;
  logic [16:0] absx, absy, absz;
  logic [1:0]  k;
  logic [35:0] prod;
  logic [35:0] v, r, b;
  logic [15:0] diff;
  logic [24:0] denom;
  logic [24:0] rem;
  logic [31:0] dvd;
  logic [5:0]  step;

  logic [17:0] mul_a, mul_b;
  logic [35:0] mul_p;
  logic [35:0] rb;
  logic [17:0] droot;
  logic [25:0] trial;
  logic signed [16:0] dx, dy, dz;

  // Listener-relative offsets.
  assign dx = {cur.pos.x[15], cur.pos.x} - {listener.x[15], listener.x};
  assign dy = {cur.pos.y[15], cur.pos.y} - {listener.y[15], listener.y};
  assign dz = {cur.pos.z[15], cur.pos.z} - {listener.z[15], listener.z};

  // Shared multiplier, operands chosen by phase.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      A_SQ: begin
        if (k == 2'd0) begin
          mul_a = 18'(absx);
        end else if (k == 2'd1) begin
          mul_a = 18'(absy);
        end else begin
          mul_a = 18'(absz);
        end
        mul_b = mul_a;
      end
      A_ROLL: begin
        mul_a = 18'(cur.lims.roll);
        mul_b = 18'(diff);
      end
      A_NUM: begin
        mul_a = 18'(cur.gain);
        mul_b = 18'(cur.lims.dmin);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign rb    = r + b;
  assign droot = r[17:0];
  assign trial = {rem, dvd[31]};

  // Sequencer: squares, bit-serial root, rolloff, restoring divide.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (start) begin
            cur <= req;
            if (req.spatial) begin
              state <= A_DIFF;
            end else begin
              level <= req.gain;
              state <= A_DONE;
            end
          end
        end
        A_DIFF: begin
          absx  <= dx[16] ? 17'(-dx) : 17'(dx);
          absy  <= dy[16] ? 17'(-dy) : 17'(dy);
          absz  <= dz[16] ? 17'(-dz) : 17'(dz);
          k     <= 2'd0;
          v     <= '0;
          state <= A_SQ;
        end
        A_SQ: begin
          // v accumulates the previous square while the next one is formed.
          prod <= mul_p;
          if (k != 2'd0) begin
            v <= v + prod;
          end
          if (k == 2'd3) begin
            r     <= '0;
            b     <= 36'd1 << 34;
            state <= A_ROOT;
          end else begin
            k <= k + 2'd1;
          end
        end
        A_ROOT: begin
          if (v >= rb) begin
            v <= v - rb;
            r <= (r >> 1) + b;
          end else begin
            r <= r >> 1;
          end
          b <= b >> 2;
          if (b == 36'd1) begin
            state <= A_CMP;
          end
        end
        A_CMP: begin
          if (droot <= 18'(cur.lims.dmin)) begin
            level <= cur.gain;
            state <= A_DONE;
          end else if (droot >= 18'(cur.lims.dmax)) begin
            level <= '0;
            state <= A_DONE;
          end else begin
            diff  <= 16'(droot - 18'(cur.lims.dmin));
            state <= A_ROLL;
          end
        end
        A_ROLL: begin
          prod  <= mul_p;
          state <= A_DEN;
        end
        A_DEN: begin
          denom <= 25'(cur.lims.dmin) + 25'(prod[31:8]);
          state <= A_NUM;
        end
        A_NUM: begin
          if (denom == '0) begin
            level <= cur.gain;
            state <= A_DONE;
          end else begin
            dvd   <= mul_p[31:0];
            rem   <= '0;
            step  <= '0;
            state <= A_DIV;
          end
        end
        A_DIV: begin
          // The quotient bits shift into the dividend register.
          if (trial >= {1'b0, denom}) begin
            rem <= 25'(trial - {1'b0, denom});
            dvd <= {dvd[30:0], 1'b1};
          end else begin
            rem <= trial[24:0];
            dvd <= {dvd[30:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == 6'd31) begin
            state <= A_DONE;
          end
        end
        A_DONE: begin
          if (cur.spatial && droot > 18'(cur.lims.dmin) && droot < 18'(cur.lims.dmax)
              && denom != '0) begin
            level <= dvd[15:0];
          end
          done  <= 1'b1;
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/voice_pool_priority_stealer.sv
// Voice pool with priority-based stealing. Stop and ended requests go from
// the accepting state straight to the result state. A play request scans the
// busy bits one slot per cycle for the lowest free slot. When the pool is
// full, the block evaluates the request's audibility and then reads every
// voice record from the slot memory and evaluates it in turn; a flat voice
// needs no arithmetic, while a spatial one may need a square root at one bit
// per cycle and a division at one quotient bit per cycle. A finished result
// waits in an output register while the next item is taken.
module voice_pool_priority_stealer #(
  parameter int VOICE_SLOTS = vps_pkg::VOICE_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  vps_cmd_if.sink                    cmd,
  vps_rsp_if.source                  rsp,
  input  logic                       cfg_we,
  input  logic [vps_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [15:0]                cfg_wdata
);
  import vps_pkg::*;

  localparam int SW = $clog2(VOICE_SLOTS);
  localparam int TW = (SW > 5) ? SW : 5;
  localparam int VW = $bits(voice_t);

  typedef enum logic [3:0] {
    S_IDLE, S_FREE, S_REQAUD, S_RD, S_RDW, S_AUD, S_DECIDE, S_WRITE, S_FIN
  } state_t;

  state_t state;

  // Configuration registers.
  pos_t        listener;
  logic [15:0] master_gain;
  logic        mute_all;

  // Pool state.
  logic [VOICE_SLOTS-1:0] busy;
  logic [15:0]            stamp;
  logic [15:0]            steal_count;

  // Current request and scan state.
  voice_t        req_rec;
  logic [15:0]   req_aud;
  logic [SW-1:0] cnt;
  logic [SW-1:0] slot;
  logic [SW-1:0] best;
  logic [7:0]    bprio;
  logic [15:0]   baud;
  logic [15:0]   bage;

  // Pending result.
  logic [1:0]  r_status;
  logic [4:0]  r_vslot;
  logic [15:0] r_dgain;
  logic        r_stole;
  logic [4:0]  r_victim;

  voice_t      rdata;
  logic [VW-1:0] rdata_bits;
  logic        aud_start;
  aud_req_t    aud_in;
  logic        aud_done;
  logic [15:0] aud_level;
  logic [TW-1:0] tgt_w;
  logic        tgt_busy;
  logic        last;
  logic [15:0] cand_age;
  logic        better;
  logic [31:0] dev_prod;

  assign cmd.ready = (state == S_IDLE);
  assign tgt_w     = TW'(cmd.target_slot);
  assign tgt_busy  = (32'(cmd.target_slot) < 32'(VOICE_SLOTS)) && busy[tgt_w[SW-1:0]];
  assign last      = (cnt == SW'(VOICE_SLOTS - 1));
  assign rdata     = voice_t'(rdata_bits);
  assign cand_age  = stamp - rdata.order;
  assign dev_prod  = 32'(req_rec.aud.gain) * 32'(master_gain);

  // Victim ordering: lowest priority, then lowest audibility, then oldest.
  assign better = (cnt == '0) || (rdata.prio < bprio) ||
                  ((rdata.prio == bprio) &&
                   ((aud_level < baud) || ((aud_level == baud) && (cand_age > bage))));

  // Audibility unit runs for the request itself and then for each voice.
  assign aud_start = ((state == S_FREE) && busy[cnt] && last) || (state == S_RDW);
  assign aud_in    = (state == S_FREE) ? req_rec.aud : rdata.aud;

  vps_ram #(
    .WIDTH (VW),
    .DEPTH (VOICE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (state == S_WRITE),
    .waddr (slot),
    .wdata (VW'({req_rec.prio, req_rec.aud, stamp})),
    .raddr (cnt),
    .rdata (rdata_bits)
  );

  vps_audibility u_aud (
    .clk      (clk),
    .rst      (rst),
    .start    (aud_start),
    .req      (aud_in),
    .listener (listener),
    .done     (aud_done),
    .level    (aud_level)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      listener    <= '0;
      master_gain <= 16'hFFFF;
      mute_all    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LISTENER_X:  listener.x  <= cfg_wdata;
        CFG_LISTENER_Y:  listener.y  <= cfg_wdata;
        CFG_LISTENER_Z:  listener.z  <= cfg_wdata;
        CFG_MASTER_GAIN: master_gain <= cfg_wdata;
        CFG_MUTE_ALL:    mute_all    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Request sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      busy        <= '0;
      stamp       <= '0;
      steal_count <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      // The output register empties unless a new result is loaded now.
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            req_rec  <= '{prio: cmd.priority_req,
                          aud: '{gain: cmd.gain, spatial: cmd.spatial,
                                 pos: '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z},
                                 lims: '{dmin: cmd.min_distance,
                                         dmax: cmd.max_distance,
                                         roll: cmd.rolloff}},
                          order: '0};
            r_dgain  <= '0;
            r_stole  <= 1'b0;
            r_victim <= '0;
            cnt      <= '0;
            case (cmd.opcode)
              OP_STOP, OP_ENDED: begin
                r_vslot <= cmd.target_slot;
                if (tgt_busy) begin
                  busy[tgt_w[SW-1:0]] <= 1'b0;
                  r_status <= ST_FREED;
                end else begin
                  r_status <= ST_NOT_BUSY;
                end
                state <= S_FIN;
              end
              OP_PLAY: begin
                r_vslot  <= '0;
                r_status <= ST_REJECTED;
                state    <= S_FREE;
              end
              default: begin
                r_vslot  <= '0;
                r_status <= ST_REJECTED;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_FREE: begin
          if (!busy[cnt]) begin
            slot  <= cnt;
            state <= S_WRITE;
          end else if (last) begin
            state <= S_REQAUD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_REQAUD: begin
          if (aud_done) begin
            req_aud <= aud_level;
            cnt     <= '0;
            state   <= S_RD;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          state <= S_AUD;
        end
        S_AUD: begin
          if (aud_done) begin
            if (better) begin
              best  <= cnt;
              bprio <= rdata.prio;
              baud  <= aud_level;
              bage  <= cand_age;
            end
            if (last) begin
              state <= S_DECIDE;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_DECIDE: begin
          if ((bprio > req_rec.prio) || ((bprio == req_rec.prio) && (baud >= req_aud))) begin
            state <= S_FIN;
          end else begin
            busy[best] <= 1'b0;
            if (steal_count != 16'hFFFF) begin
              steal_count <= steal_count + 16'd1;
            end
            r_stole  <= 1'b1;
            r_victim <= 5'(best);
            slot     <= best;
            state    <= S_WRITE;
          end
        end
        S_WRITE: begin
          busy[slot] <= 1'b1;
          stamp      <= stamp + 16'd1;
          r_status   <= ST_STARTED;
          r_vslot    <= 5'(slot);
          r_dgain    <= mute_all ? 16'd0 : dev_prod[31:16];
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= r_status;
            rsp.voice_slot   <= r_vslot;
            rsp.device_gain  <= r_dgain;
            rsp.stole        <= r_stole;
            rsp.victim_slot  <= r_victim;
            rsp.stolen_total <= steal_count;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The audibility unit only finishes while the sequencer waits for it.
  a_aud_done_waited: assert property (@(posedge clk) disable iff (rst)
    aud_done |-> (state == S_REQAUD || state == S_AUD))
    else $error("audibility result arrived while not awaited");

  // A new voice is only written into a slot that is free at that point.
  a_write_free_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> !busy[slot])
    else $error("voice written over a busy slot");

  // The steal count never goes down.
  a_steal_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> steal_count >= $past(steal_count))
    else $error("steal count decreased");

endmodule

FILE: verif/vps_tb_pkg.sv
package vps_tb_pkg;

  // One request item as the stimulus queue holds it.
  typedef struct {
    logic [1:0]  opcode;
    logic [4:0]  target_slot;
    logic [7:0]  priority_req;
    logic [15:0] gain;
    logic        spatial;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] min_distance;
    logic [15:0] max_distance;
    logic [15:0] rolloff;
  } voice_req_t;

  // One answer item.
  typedef struct {
    logic [1:0]  status;
    logic [4:0]  voice_slot;
    logic [15:0] device_gain;
    logic        stole;
    logic [4:0]  victim_slot;
    logic [15:0] stolen_total;
  } voice_ans_t;

endpackage

FILE: verif/tb_voice_pool_priority_stealer.sv
module tb_voice_pool_priority_stealer;
  import vps_pkg::*;
  import vps_tb_pkg::*;

  localparam int NSLOT = 32;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  vps_cmd_if cmd ();
  vps_rsp_if rsp ();

  voice_pool_priority_stealer dut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: pool contents and register copies.
  logic signed [15:0] lis_x, lis_y, lis_z;
  logic [15:0] mgain;
  logic        muted;
  logic        busy [NSLOT];
  logic [7:0]  v_prio [NSLOT];
  logic [15:0] v_gain [NSLOT];
  logic        v_spat [NSLOT];
  logic signed [15:0] v_x [NSLOT], v_y [NSLOT], v_z [NSLOT];
  logic [15:0] v_min [NSLOT], v_max [NSLOT], v_roll [NSLOT];
  logic [15:0] v_order [NSLOT];
  logic [15:0] order_stamp;
  logic [15:0] steal_count;

  voice_req_t pending_reqs[$];
  voice_ans_t expected_answers[$];
  int errors = 0;
  int accepted = 0;
  int answers = 0;
  int steals_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int idle_cycles = 0;

  function automatic logic [31:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 34;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  // Loudness of a voice as heard at the listener.
  function automatic logic [31:0] loudness(logic [15:0] g, logic sp,
      logic signed [15:0] px, logic signed [15:0] py, logic signed [15:0] pz,
      logic [15:0] dmin, logic [15:0] dmax, logic [15:0] roll);
    longint dx, dy, dz;
    logic [63:0] t;
    logic [31:0] d, den;
    if (!sp) return {16'd0, g};
    dx = longint'(px) - longint'(lis_x);
    dy = longint'(py) - longint'(lis_y);
    dz = longint'(pz) - longint'(lis_z);
    d = int_sqrt(64'(dx * dx + dy * dy + dz * dz));
    if (d <= dmin) return {16'd0, g};
    if (d >= dmax) return '0;
    t = (64'(roll) * 64'(d - dmin)) >> 8;
    den = dmin + t[31:0];
    if (den == 0) return {16'd0, g};
    return 32'((64'(g) * 64'(dmin)) / 64'(den));
  endfunction

  // Apply one request to the pool copy and return the answer it gives.
  function automatic voice_ans_t allocate_voice(voice_req_t q);
    voice_ans_t a;
    int slot, best;
    logic [31:0] la, best_la;
    logic [15:0] age, best_age;
    logic [7:0] best_prio;
    a = '{status: ST_REJECTED, voice_slot: '0, device_gain: '0, stole: 1'b0,
          victim_slot: '0, stolen_total: '0};
    if (q.opcode == OP_STOP || q.opcode == OP_ENDED) begin
      a.voice_slot = q.target_slot;
      if (busy[q.target_slot]) begin
        busy[q.target_slot] = 1'b0;
        a.status = ST_FREED;
      end else begin
        a.status = ST_NOT_BUSY;
      end
    end else if (q.opcode == OP_PLAY) begin
      slot = -1;
      for (int i = 0; i < NSLOT; i++)
        if (!busy[i] && slot < 0) slot = i;
      if (slot < 0) begin
        best = -1;
        best_la = '0; best_age = '0; best_prio = '0;
        for (int i = 0; i < NSLOT; i++) begin
          la = loudness(v_gain[i], v_spat[i], v_x[i], v_y[i], v_z[i],
                        v_min[i], v_max[i], v_roll[i]);
          age = order_stamp - v_order[i];
          if (best < 0 || v_prio[i] < best_prio || (v_prio[i] == best_prio &&
              (la < best_la || (la == best_la && age > best_age)))) begin
            best = i; best_prio = v_prio[i]; best_la = la; best_age = age;
          end
        end
        if (!(best_prio > q.priority_req || (best_prio == q.priority_req &&
            best_la >= loudness(q.gain, q.spatial, q.pos_x, q.pos_y, q.pos_z,
                                q.min_distance, q.max_distance, q.rolloff)))) begin
          if (steal_count != 16'hFFFF) steal_count++;
          a.stole = 1'b1;
          a.victim_slot = best[4:0];
          slot = best;
        end
      end
      if (slot >= 0) begin
        busy[slot] = 1'b1;
        v_prio[slot] = q.priority_req;
        v_gain[slot] = q.gain;
        v_spat[slot] = q.spatial;
        v_x[slot] = q.pos_x; v_y[slot] = q.pos_y; v_z[slot] = q.pos_z;
        v_min[slot] = q.min_distance; v_max[slot] = q.max_distance;
        v_roll[slot] = q.rolloff;
        v_order[slot] = order_stamp;
        order_stamp++;
        a.status = ST_STARTED;
        a.voice_slot = slot[4:0];
        a.device_gain = muted ? 16'd0 : 16'((32'(q.gain) * 32'(mgain)) >> 16);
      end
    end
    a.stolen_total = steal_count;
    return a;
  endfunction

  // Append one item to the stimulus queue.
  task automatic add_req(voice_req_t q);
    pending_reqs = {pending_reqs, q};
  endtask

  // Driver: offer queued items, idling at random.
  always @(posedge clk) begin
    voice_req_t taken;
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (!cmd.valid || cmd.ready) begin
      if (cmd.valid) begin
        taken = pending_reqs.pop_front();
        expected_answers = {expected_answers, allocate_voice(taken)};
        accepted++;
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        voice_req_t q;
        q = pending_reqs[0];
        cmd.valid <= 1'b1;
        cmd.opcode <= q.opcode; cmd.target_slot <= q.target_slot;
        cmd.priority_req <= q.priority_req; cmd.gain <= q.gain;
        cmd.spatial <= q.spatial;
        cmd.pos_x <= q.pos_x; cmd.pos_y <= q.pos_y; cmd.pos_z <= q.pos_z;
        cmd.min_distance <= q.min_distance; cmd.max_distance <= q.max_distance;
        cmd.rolloff <= q.rolloff;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each answer with the oldest expectation.
  always @(posedge clk) begin
    voice_ans_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        answers++;
        if (rsp.stole) steals_seen++;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected answer status=%0d slot=%0d", $time,
                   rsp.status, rsp.voice_slot);
          errors++;
        end else begin
          e = expected_answers.pop_front();
          if (e.status !== rsp.status || e.voice_slot !== rsp.voice_slot ||
              e.device_gain !== rsp.device_gain || e.stole !== rsp.stole ||
              e.victim_slot !== rsp.victim_slot ||
              e.stolen_total !== rsp.stolen_total) begin
            $display("%0t: mismatch expected st=%0d slot=%0d gain=%0d stole=%0d vic=%0d tot=%0d",
                     $time, e.status, e.voice_slot, e.device_gain, e.stole,
                     e.victim_slot, e.stolen_total);
            $display("%0t:          actual   st=%0d slot=%0d gain=%0d stole=%0d vic=%0d tot=%0d",
                     $time, rsp.status, rsp.voice_slot, rsp.device_gain, rsp.stole,
                     rsp.victim_slot, rsp.stolen_total);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LISTENER_X: lis_x = val;
      CFG_LISTENER_Y: lis_y = val;
      CFG_LISTENER_Z: lis_z = val;
      CFG_MASTER_GAIN: mgain = val;
      CFG_MUTE_ALL: muted = val[0];
      default: ;
    endcase
  endtask

  // Wait until every queued item went in and every answer came back.
  task automatic drain();
    while (pending_reqs.size() != 0 || cmd.valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic voice_req_t rand_req(int play_pct);
    voice_req_t q;
    q.opcode = ($urandom_range(99) < play_pct) ? OP_PLAY :
               ($urandom_range(9) == 0 ? OP_UNUSED :
               ($urandom_range(1) ? OP_STOP : OP_ENDED));
    q.target_slot = 5'($urandom);
    q.priority_req = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    q.gain = 16'($urandom);
    q.spatial = 1'($urandom);
    // Mostly positions near the listener so that rolloff matters.
    q.pos_x = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4000) - 2000);
    q.pos_y = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4000) - 2000);
    q.pos_z = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4000) - 2000);
    q.min_distance = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(1500));
    q.max_distance = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(6000));
    q.rolloff = 16'($urandom);
    return q;
  endfunction

  function automatic voice_req_t play(logic [7:0] p, logic [15:0] g, logic sp,
      logic [15:0] x, logic [15:0] mn, logic [15:0] mx, logic [15:0] r);
    voice_req_t q;
    q = '{opcode: OP_PLAY, target_slot: '0, priority_req: p, gain: g, spatial: sp,
          pos_x: x, pos_y: '0, pos_z: '0, min_distance: mn, max_distance: mx,
          rolloff: r};
    return q;
  endfunction

  initial begin
    voice_req_t q;
    int phase_idle[4] = '{0, 62, 0, 32};
    int phase_stall[4] = '{0, 0, 62, 32};
    cmd.valid = 1'b0;
    cmd.opcode = OP_PLAY; cmd.target_slot = '0; cmd.priority_req = '0; cmd.gain = '0;
    cmd.spatial = 1'b0; cmd.pos_x = '0; cmd.pos_y = '0; cmd.pos_z = '0;
    cmd.min_distance = '0; cmd.max_distance = '0; cmd.rolloff = '0;
    rsp.ready = 1'b0;
    lis_x = '0; lis_y = '0; lis_z = '0; mgain = 16'hFFFF; muted = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      busy[i] = 1'b0; v_prio[i] = '0; v_gain[i] = '0; v_spat[i] = 1'b0;
      v_x[i] = '0; v_y[i] = '0; v_z[i] = '0; v_min[i] = '0; v_max[i] = '0;
      v_roll[i] = '0; v_order[i] = '0;
    end
    order_stamp = '0; steal_count = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, unused opcode, stops of a free and a busy slot, then a
    // full pool with steals and an equal-priority tie.
    add_req(play(8'd0, 16'hFFFF, 1'b0, 16'h0000, 16'd0, 16'd0, 16'd0));
    add_req(play(8'hFF, 16'h0000, 1'b1, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_req(play(8'd5, 16'h8000, 1'b1, 16'h8000, 16'd0, 16'hFFFF, 16'd0));
    add_req(play(8'd5, 16'h1234, 1'b1, 16'h0400, 16'h0100, 16'h2000, 16'h0100));
    add_req(play(8'd5, 16'h1234, 1'b1, 16'h0400, 16'h0100, 16'h0200, 16'h0100));
    q = rand_req(0); q.opcode = OP_UNUSED; add_req(q);
    q.opcode = OP_STOP; q.target_slot = 5'd31; add_req(q);
    q.opcode = OP_ENDED; q.target_slot = 5'd1; add_req(q);
    for (int i = 0; i < 28; i++)
      add_req(play(8'd3, 16'h4000, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    add_req(play(8'd2, 16'h9000, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    add_req(play(8'd3, 16'h4000, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    add_req(play(8'd3, 16'h5000, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    drain();

    // Register extremes, each followed by a random phase with its own idling.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      write_reg(CFG_LISTENER_X, ph[0] ? 16'h8000 : 16'($urandom_range(600) - 300));
      write_reg(CFG_LISTENER_Y, ph == 2 ? 16'h7FFF : 16'h0000);
      write_reg(CFG_LISTENER_Z, 16'($urandom_range(400) - 200));
      write_reg(CFG_MASTER_GAIN, ph == 1 ? 16'h0000 : (ph == 3 ? 16'h8001 : 16'hFFFF));
      write_reg(CFG_MUTE_ALL, 16'(ph == 2));
      if (ph == 0) hold_off = 200;
      for (int n = 0; n < 95; n++) add_req(rand_req(75));
      drain();
    end

    $display("Ran %0d items through %0d answers with %0d steals,", accepted, answers,
             steals_seen);
    $display("over four idling phases and register extremes.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
